FILE: hdl/i2cms_pkg.sv
// types and codes shared by the i2c master byte sequencer
`default_nettype none

package i2cms_pkg;

    localparam int PhaseWidth = 16;
    localparam int StepWidth  = 5;

    // request codes on the command channel
    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_START = 3'd1;
    localparam logic [2:0] REQ_STOP  = 3'd2;
    localparam logic [2:0] REQ_WRITE = 3'd3;
    localparam logic [2:0] REQ_READ  = 3'd4;

    localparam logic [StepWidth-1:0] STEP_IDLE       = 5'd0;
    localparam logic [StepWidth-1:0] STEP_FIRST      = 5'd1;
    localparam logic [StepWidth-1:0] STEP_LAST_SHORT = 5'd2;
    localparam logic [StepWidth-1:0] STEP_LAST_READ  = 5'd17;
    localparam logic [StepWidth-1:0] STEP_LAST_WRITE = 5'd18;
    localparam logic [StepWidth-1:0] STEP_ACK_SLOT   = 5'd16;
    localparam logic [StepWidth-1:0] STEP_LAST_BIT   = 5'd15;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } req_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic       ack_seen;
        logic [7:0] rx_byte;
        logic       rejected;
    } res_t;

endpackage

`default_nettype wire

FILE: hdl/i2c_master_byte_sequencer.sv
// i2c master byte sequencer: command and tick driven scl/sda control
// the result transaction is registered from the accepted transaction and presented in the following cycle
// throughput: one transaction per cycle unless an unaccepted result holds s_ready low; the state
// update and result are computed in one pass and stored in the result register
// reset: aresetn synchronous active low; scl and sda driven high, sequencer idle,
// phase_ticks returns to one
`default_nettype none

module i2c_master_byte_sequencer (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [15:0]           cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire i2cms_pkg::req_t       s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output i2cms_pkg::res_t            m_data
);

    logic [i2cms_pkg::PhaseWidth-1:0] phase_ticks_reg;
    logic                             scl_reg, scl_next;
    logic                             sda_reg, sda_next;
    logic                             drive_reg, drive_next;
    logic [i2cms_pkg::StepWidth-1:0]  step_reg, step_next;
    i2cms_pkg::op_t                   op_reg, op_next;
    logic [7:0]                       shift_reg, shift_next;
    logic [i2cms_pkg::PhaseWidth-1:0] count_reg, count_next;
    logic                             ack_mode_reg, ack_mode_next;
    logic                             last_ack_reg, last_ack_next;
    logic [7:0]                       rx_hold_reg, rx_hold_next;
    logic                             m_valid_reg, m_valid_next;
    i2cms_pkg::res_t                  m_data_reg, m_data_next;

    logic                             s_fire;
    logic                             done;
    logic                             rej;
    logic [i2cms_pkg::PhaseWidth-1:0] count_inc;
    logic [i2cms_pkg::PhaseWidth-1:0] phase_len;
    logic [i2cms_pkg::StepWidth-1:0]  last_step;
    logic [7:0]                       shift_up;
    logic [7:0]                       shift_in;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign count_inc = count_reg + 16'd1;
    assign phase_len = (phase_ticks_reg == '0) ? 16'd1 : phase_ticks_reg;
    assign shift_up  = {shift_reg[6:0], 1'b0};
    assign shift_in  = {shift_reg[6:0], s_data.sda_in};

    always_comb begin
        unique case (op_reg)
            i2cms_pkg::OP_WRITE: last_step = i2cms_pkg::STEP_LAST_WRITE;
            i2cms_pkg::OP_READ:  last_step = i2cms_pkg::STEP_LAST_READ;
            default:             last_step = i2cms_pkg::STEP_LAST_SHORT;
        endcase
    end

    always_comb begin
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        drive_next    = drive_reg;
        step_next     = step_reg;
        op_next       = op_reg;
        shift_next    = shift_reg;
        count_next    = count_reg;
        ack_mode_next = ack_mode_reg;
        last_ack_next = last_ack_reg;
        rx_hold_next  = rx_hold_reg;
        done          = 1'b0;
        rej           = 1'b0;

        if (s_fire) begin
            unique case (s_data.req_type)
                i2cms_pkg::REQ_START, i2cms_pkg::REQ_STOP,
                i2cms_pkg::REQ_WRITE, i2cms_pkg::REQ_READ: begin
                    if (step_reg != i2cms_pkg::STEP_IDLE) begin
                        rej = 1'b1;
                    end else begin
                        count_next = '0;
                        step_next  = i2cms_pkg::STEP_FIRST;
                        unique case (s_data.req_type)
                            i2cms_pkg::REQ_START: begin
                                op_next    = i2cms_pkg::OP_START;
                                sda_next   = 1'b1;
                                drive_next = 1'b1;
                                scl_next   = 1'b1;
                            end
                            i2cms_pkg::REQ_STOP: begin
                                op_next    = i2cms_pkg::OP_STOP;
                                sda_next   = 1'b0;
                                drive_next = 1'b1;
                                scl_next   = 1'b1;
                            end
                            i2cms_pkg::REQ_WRITE: begin
                                op_next    = i2cms_pkg::OP_WRITE;
                                shift_next = s_data.tx_byte;
                                sda_next   = s_data.tx_byte[7];
                            end
                            default: begin
                                op_next       = i2cms_pkg::OP_READ;
                                ack_mode_next = s_data.send_ack;
                                shift_next    = '0;
                                drive_next    = 1'b0;
                                sda_next      = 1'b1;
                                scl_next      = 1'b1;
                            end
                        endcase
                    end
                end
                i2cms_pkg::REQ_TICK: begin
                    if (step_reg != i2cms_pkg::STEP_IDLE) begin
                        if (count_inc >= phase_len || count_inc == '0) begin
                            count_next = '0;
                            if (step_reg >= last_step) begin
                                // final phase of the command
                                done      = 1'b1;
                                step_next = i2cms_pkg::STEP_IDLE;
                                unique case (op_reg)
                                    i2cms_pkg::OP_STOP: sda_next = 1'b1;
                                    i2cms_pkg::OP_WRITE: begin
                                        last_ack_next = !s_data.sda_in;
                                        scl_next      = 1'b0;
                                        drive_next    = 1'b1;
                                    end
                                    default: scl_next = 1'b0;
                                endcase
                            end else begin
                                step_next = step_reg + 5'd1;
                                unique case (op_reg)
                                    i2cms_pkg::OP_START: sda_next = 1'b0;
                                    i2cms_pkg::OP_STOP:  sda_next = 1'b1;
                                    i2cms_pkg::OP_WRITE: begin
                                        if (step_reg[0]) begin
                                            scl_next = 1'b1;
                                        end else begin
                                            scl_next   = 1'b0;
                                            shift_next = shift_up;
                                            if (step_reg < i2cms_pkg::STEP_ACK_SLOT) begin
                                                sda_next = shift_up[7];
                                            end else begin
                                                drive_next = 1'b0;
                                                sda_next   = 1'b1;
                                            end
                                        end
                                    end
                                    default: begin
                                        if (step_reg[0]) begin
                                            shift_next = shift_in;
                                            scl_next   = 1'b0;
                                            if (step_reg == i2cms_pkg::STEP_LAST_BIT) begin
                                                rx_hold_next = shift_in;
                                                drive_next   = 1'b1;
                                                sda_next     = !ack_mode_reg;
                                            end
                                        end else begin
                                            scl_next = 1'b1;
                                        end
                                    end
                                endcase
                            end
                        end else begin
                            count_next = count_inc;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        m_data_next.scl_out   = scl_next;
        m_data_next.sda_out   = sda_next;
        m_data_next.sda_drive = drive_next;
        m_data_next.busy_res  = (step_next != i2cms_pkg::STEP_IDLE);
        m_data_next.done_res  = done;
        m_data_next.ack_seen  = last_ack_next;
        m_data_next.rx_byte   = rx_hold_next;
        m_data_next.rejected  = rej;

        if (s_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= 16'd1;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            drive_reg       <= 1'b1;
            step_reg        <= i2cms_pkg::STEP_IDLE;
            op_reg          <= i2cms_pkg::OP_START;
            shift_reg       <= '0;
            count_reg       <= '0;
            ack_mode_reg    <= 1'b0;
            last_ack_reg    <= 1'b0;
            rx_hold_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                phase_ticks_reg <= cfg_data;
            end
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            drive_reg    <= drive_next;
            step_reg     <= step_next;
            op_reg       <= op_next;
            shift_reg    <= shift_next;
            count_reg    <= count_next;
            ack_mode_reg <= ack_mode_next;
            last_ack_reg <= last_ack_next;
            rx_hold_reg  <= rx_hold_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// self-checking testbench for the i2c master byte sequencer with a pin-state scoreboard
module testbench;

    localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [2:0] REQ_UNUSED_HI = 3'd7;
    localparam int         PHASE_ITEMS   = 125;

    class pin_scoreboard;
        logic [15:0]                     phase_len;
        logic                            scl, sda, drv;
        logic [i2cms_pkg::StepWidth-1:0] step;
        i2cms_pkg::op_t                  op;
        logic [7:0]                      shift;
        logic [15:0]                     count;
        logic                            ack_mode, last_ack;
        logic [7:0]                      rx_hold;
        i2cms_pkg::res_t                 due_pins[$];
        int                              errors;
        int                              checked;
        int                              taken;

        function new();
            phase_len = 16'd1;
            scl = 1'b1;
            sda = 1'b1;
            drv = 1'b1;
            step = i2cms_pkg::STEP_IDLE;
            op = i2cms_pkg::OP_START;
            shift = 8'h00;
            count = 16'h0000;
            ack_mode = 1'b0;
            last_ack = 1'b0;
            rx_hold = 8'h00;
            errors = 0;
            checked = 0;
            taken = 0;
        endfunction

        function void set_phase_len(logic [15:0] v);
            phase_len = v;
        endfunction

        function int pending();
            return due_pins.size();
        endfunction

        function bit busy();
            return step != i2cms_pkg::STEP_IDLE;
        endfunction

        function logic [i2cms_pkg::StepWidth-1:0] last_step();
            if (op == i2cms_pkg::OP_WRITE) return i2cms_pkg::STEP_LAST_WRITE;
            if (op == i2cms_pkg::OP_READ) return i2cms_pkg::STEP_LAST_READ;
            return i2cms_pkg::STEP_LAST_SHORT;
        endfunction

        // actions at the end of the current phase, returns 1 when the command finishes
        function bit end_phase(logic sda_in);
            logic [i2cms_pkg::StepWidth-1:0] s;
            s = step;
            if (s >= last_step()) begin
                case (op)
                    i2cms_pkg::OP_START: scl = 1'b0;
                    i2cms_pkg::OP_STOP:  sda = 1'b1;
                    i2cms_pkg::OP_WRITE: begin
                        last_ack = ~sda_in;
                        scl = 1'b0;
                        drv = 1'b1;
                    end
                    default:  scl = 1'b0;
                endcase
                return 1'b1;
            end
            case (op)
                i2cms_pkg::OP_START: sda = 1'b0;
                i2cms_pkg::OP_STOP:  sda = 1'b1;
                i2cms_pkg::OP_WRITE: begin
                    if (s[0]) begin
                        scl = 1'b1;
                    end else begin
                        scl = 1'b0;
                        shift = {shift[6:0], 1'b0};
                        if (s < i2cms_pkg::STEP_ACK_SLOT) begin
                            sda = shift[7];
                        end else begin
                            drv = 1'b0;
                            sda = 1'b1;
                        end
                    end
                end
                default: begin
                    if (s[0]) begin
                        shift = {shift[6:0], sda_in};
                        scl = 1'b0;
                        if (s == i2cms_pkg::STEP_LAST_BIT) begin
                            rx_hold = shift;
                            drv = 1'b1;
                            sda = ~ack_mode;
                        end
                    end else begin
                        scl = 1'b1;
                    end
                end
            endcase
            step = s + 5'd1;
            return 1'b0;
        endfunction

        function void note_request(i2cms_pkg::req_t r);
            i2cms_pkg::res_t e;
            logic            done, rej;
            logic [15:0]     len;
            done = 1'b0;
            rej = 1'b0;
            taken++;
            case (r.req_type)
                i2cms_pkg::REQ_START, i2cms_pkg::REQ_STOP,
                i2cms_pkg::REQ_WRITE, i2cms_pkg::REQ_READ: begin
                    if (step != i2cms_pkg::STEP_IDLE) begin
                        rej = 1'b1;
                    end else begin
                        count = 16'h0000;
                        step = i2cms_pkg::STEP_FIRST;
                        case (r.req_type)
                            i2cms_pkg::REQ_START: begin
                                op = i2cms_pkg::OP_START;
                                sda = 1'b1;
                                drv = 1'b1;
                                scl = 1'b1;
                            end
                            i2cms_pkg::REQ_STOP: begin
                                op = i2cms_pkg::OP_STOP;
                                sda = 1'b0;
                                drv = 1'b1;
                                scl = 1'b1;
                            end
                            i2cms_pkg::REQ_WRITE: begin
                                op = i2cms_pkg::OP_WRITE;
                                shift = r.tx_byte;
                                sda = r.tx_byte[7];
                            end
                            default: begin
                                op = i2cms_pkg::OP_READ;
                                ack_mode = r.send_ack;
                                shift = 8'h00;
                                drv = 1'b0;
                                sda = 1'b1;
                                scl = 1'b1;
                            end
                        endcase
                    end
                end
                i2cms_pkg::REQ_TICK: begin
                    if (step != i2cms_pkg::STEP_IDLE) begin
                        len = (phase_len == 16'h0000) ? 16'h0001 : phase_len;
                        count = count + 16'h0001;
                        if (count >= len || count == 16'h0000) begin
                            count = 16'h0000;
                            if (end_phase(r.sda_in)) begin
                                step = i2cms_pkg::STEP_IDLE;
                                done = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
            e.scl_out = scl;
            e.sda_out = sda;
            e.sda_drive = drv;
            e.busy_res = step != i2cms_pkg::STEP_IDLE;
            e.done_res = done;
            e.ack_seen = last_ack;
            e.rx_byte = rx_hold;
            e.rejected = rej;
            due_pins.push_back(e);
        endfunction

        function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t mismatch %s expected %0h actual %0h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_pins(i2cms_pkg::res_t got);
            i2cms_pkg::res_t e;
            if (due_pins.size() == 0) begin
                errors++;
                $display("%0t unexpected result expected none actual %0h", $time, got);
                return;
            end
            e = due_pins.pop_front();
            checked++;
            compare_field("scl_out", 8'(e.scl_out), 8'(got.scl_out));
            compare_field("sda_out", 8'(e.sda_out), 8'(got.sda_out));
            compare_field("sda_drive", 8'(e.sda_drive), 8'(got.sda_drive));
            compare_field("busy_res", 8'(e.busy_res), 8'(got.busy_res));
            compare_field("done_res", 8'(e.done_res), 8'(got.done_res));
            compare_field("ack_seen", 8'(e.ack_seen), 8'(got.ack_seen));
            compare_field("rx_byte", e.rx_byte, got.rx_byte);
            compare_field("rejected", 8'(e.rejected), 8'(got.rejected));
        endfunction
    endclass

    logic            aclk;
    logic            aresetn;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [15:0]     cfg_data;
    logic            s_valid;
    logic            s_ready;
    i2cms_pkg::req_t s_data;
    logic            m_valid;
    logic            m_ready;
    i2cms_pkg::res_t m_data;

    pin_scoreboard sb;
    bit            calm;
    int            ready_hold;

    i2c_master_byte_sequencer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // result side: check every transaction, stall in random bursts unless calm
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_pins(m_data);
        if (!aresetn || calm) begin
            ready_hold = 0;
            m_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            ready_hold = $urandom_range(1, 8) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_req(input i2cms_pkg::req_t r);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(r);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_phase_len(input logic [15:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_phase_len(v);
        cfg_valid <= 1'b0;
    endtask

    function automatic i2cms_pkg::req_t pick_req(bit busy);
        i2cms_pkg::req_t r;
        int              k;
        int              b;
        b = $urandom_range(0, 7);
        r.tx_byte = (b == 0) ? 8'h00 : (b == 1) ? 8'hFF : 8'($urandom);
        r.send_ack = 1'($urandom);
        r.sda_in = 1'($urandom);
        k = $urandom_range(0, 99);
        if (!busy) begin
            if (k < 80) begin
                r.req_type = 3'($urandom_range(i2cms_pkg::REQ_START, i2cms_pkg::REQ_READ));
            end else if (k < 90) begin
                r.req_type = i2cms_pkg::REQ_TICK;
            end else begin
                r.req_type = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
            end
        end else begin
            if (k < 88) begin
                r.req_type = i2cms_pkg::REQ_TICK;
            end else if (k < 95) begin
                r.req_type = 3'($urandom_range(i2cms_pkg::REQ_START, i2cms_pkg::REQ_READ));
            end else begin
                r.req_type = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
            end
        end
        return r;
    endfunction

    initial begin
        logic [15:0]     phase_plan [6];
        i2cms_pkg::req_t r;
        int              counted;
        bit              was_busy;

        phase_plan = '{16'd2, 16'd1, 16'd0, 16'd3, 16'd4, 16'd1};
        sb = new();
        calm = 1'b0;
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= 16'h0000;
        s_valid <= 1'b0;
        s_data <= '0;
        m_ready <= 1'b1;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle ticks, unused codes, rejection while busy
        send_req(i2cms_pkg::req_t'{i2cms_pkg::REQ_TICK, 8'h00, 1'b0, 1'b1});
        send_req(i2cms_pkg::req_t'{REQ_UNUSED_LO, 8'h00, 1'b0, 1'b0});
        send_req(i2cms_pkg::req_t'{REQ_UNUSED_HI, 8'hFF, 1'b1, 1'b1});
        send_req(i2cms_pkg::req_t'{i2cms_pkg::REQ_START, 8'h00, 1'b0, 1'b0});
        send_req(i2cms_pkg::req_t'{i2cms_pkg::REQ_WRITE, 8'hA5, 1'b1, 1'b0});
        send_req(i2cms_pkg::req_t'{REQ_UNUSED_HI, 8'h00, 1'b0, 1'b0});
        send_req(i2cms_pkg::req_t'{i2cms_pkg::REQ_TICK, 8'h00, 1'b0, 1'b0});
        send_req(i2cms_pkg::req_t'{i2cms_pkg::REQ_TICK, 8'h00, 1'b0, 1'b1});
        send_req(i2cms_pkg::req_t'{i2cms_pkg::REQ_STOP, 8'hFF, 1'b1, 1'b1});
        send_req(i2cms_pkg::req_t'{i2cms_pkg::REQ_TICK, 8'h00, 1'b0, 1'b0});
        send_req(i2cms_pkg::req_t'{i2cms_pkg::REQ_TICK, 8'h00, 1'b0, 1'b1});

        // zero phase length behaves as one tick
        write_phase_len(16'h0000);
        send_req(i2cms_pkg::req_t'{i2cms_pkg::REQ_START, 8'h00, 1'b0, 1'b1});
        send_req(i2cms_pkg::req_t'{i2cms_pkg::REQ_TICK, 8'h00, 1'b0, 1'b0});
        send_req(i2cms_pkg::req_t'{i2cms_pkg::REQ_TICK, 8'h00, 1'b0, 1'b1});

        // longest phase, then shortened mid-phase by the first random setting
        write_phase_len(16'hFFFF);
        send_req(i2cms_pkg::req_t'{i2cms_pkg::REQ_WRITE, 8'h00, 1'b0, 1'b0});
        repeat (5) send_req(i2cms_pkg::req_t'{i2cms_pkg::REQ_TICK, 8'h00, 1'b0, 1'b1});

        foreach (phase_plan[p]) begin
            write_phase_len(phase_plan[p]);
            if (p == $size(phase_plan) - 1) calm = 1'b1;
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                was_busy = sb.busy();
                r = pick_req(was_busy);
                send_req(r);
                if ((r.req_type >= i2cms_pkg::REQ_START && r.req_type <= i2cms_pkg::REQ_READ)
                        || (r.req_type == i2cms_pkg::REQ_TICK && was_busy))
                    counted++;
            end
        end

        drain();
        repeat (4) @(posedge aclk);
        $display("sent %0d command and tick transactions, compared %0d results", sb.taken,
                 sb.checked);
        $display("phase lengths 0 to 4 and 65535, rejects, unused codes, acks and nacks");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #3200000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
